[sv/aie_pkg.sv]
// Shared types and constants for the arithmetic interval encoder.
`timescale 1ns / 1ps

package aie_pkg;

    // Fixed-point format: Q1.FRAC_BITS, 2^FRAC_BITS means 1.0
    localparam int FRAC_BITS = 32;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int SYM_W     = 8;
    localparam logic [VAL_W-1:0] FX_ONE = VAL_W'(1) << FRAC_BITS;

    // Symbol table depth default
    localparam int DEF_MAX_SYMBOLS = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_ENCODE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]       operation;
        logic [SYM_W-1:0] symbol;
        logic [VAL_W-1:0] probability;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] interval_lower;
        logic [VAL_W-1:0] interval_upper;
        logic [VAL_W-1:0] code_value;
        logic             code_valid;
        logic [1:0]       status;
    } t_out_item;

    // Classified command held in the queue
    typedef struct packed {
        t_op              kind;
        logic [SYM_W-1:0] symbol;
        logic [VAL_W-1:0] prob;
        logic             last;
    } t_cmd;

    // Queue write request driven by the front
    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

endpackage

[sv/aie_ram.sv]
// Generic RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps

module aie_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/aie_front.sv]
// Front end: takes input items, classifies the operation, saturates probability.
`timescale 1ns / 1ps

module aie_front import aie_pkg::*; (
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output t_q_wr    o_q_wr,
    output t_cmd     o_cmd
);

    // Accept whenever the queue has room
    assign o_in_ready  = !i_q_full;
    assign o_q_wr.push = i_in_valid && !i_q_full;
    assign o_q_wr.full = i_q_full;

    // Classify and normalize the payload
    always_comb begin
        o_cmd.kind   = t_op'(i_in_item.operation);
        o_cmd.symbol = i_in_item.symbol;
        o_cmd.prob   = (i_in_item.probability > FX_ONE) ? FX_ONE : i_in_item.probability;
        // last only matters for encode
        o_cmd.last   = i_in_item.last && (t_op'(i_in_item.operation) == OP_ENCODE);
    end

endmodule

[sv/aie_queue.sv]
// Short FIFO of classified commands between front and back.
`timescale 1ns / 1ps

module aie_queue import aie_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    input  t_cmd  i_cmd,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_cmd  o_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic          push, pop;

    assign push = i_wr.push;
    assign pop  = i_pop && (r_cnt != '0);

    // Pointer and count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rptr];

endmodule

[sv/aie_back.sv]
// Back end: symbol table, interval update and output register.
`timescale 1ns / 1ps

module aie_back import aie_pkg::*; #(
    parameter  int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
    localparam int ADDR_W      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1,
    localparam int COUNT_W     = $clog2(MAX_SYMBOLS + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int PROD_W = 2 * VAL_W;

    // Table state
    logic [SYM_W-1:0]   r_sym [MAX_SYMBOLS];
    logic [COUNT_W-1:0] r_count;
    logic [VAL_W-1:0]   r_cum;

    // Interval state
    logic [VAL_W-1:0]   r_lower, n_lower;
    logic [VAL_W-1:0]   r_upper, n_upper;

    // Execute stage registers
    logic               r_s2_valid;
    t_op                r_s2_kind;
    logic               r_s2_found;
    logic               r_s2_full;
    logic               r_s2_last;

    logic               r_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic               adv, pop;
    logic               found;
    logic [ADDR_W-1:0]  idx;
    logic               full;
    logic [VAL_W:0]     top_sum;
    logic [VAL_W-1:0]   top;
    logic               do_add;
    logic [2*VAL_W-1:0] seg_data;
    logic [VAL_W-1:0]   seg_lo, seg_hi;
    logic [VAL_W-1:0]   span;
    logic [PROD_W-1:0]  prod_lo, prod_hi;
    logic [VAL_W-1:0]   nlo, nhi;
    logic [VAL_W:0]     mid_sum;

    // Whole back end moves when the output register is free or drained
    assign adv   = !r_out_valid || i_out_ready;
    assign pop   = adv && i_cmd_valid;
    assign o_pop = pop;

    // Lookup: first matching entry below the fill count
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
            if ((COUNT_W'(i) < r_count) && (r_sym[i] == i_cmd.symbol)) begin
                found = 1'b1;
                idx   = ADDR_W'(i);
            end
        end
    end

    // Add path: new segment top, saturated at one
    always_comb begin
        full    = (r_count == COUNT_W'(MAX_SYMBOLS));
        top_sum = {1'b0, r_cum} + {1'b0, i_cmd.prob};
        top     = (top_sum > {1'b0, FX_ONE}) ? FX_ONE : top_sum[VAL_W-1:0];
        do_add  = pop && (i_cmd.kind == OP_ADD) && !full;
    end

    // Segment bounds memory, {upper, lower}
    aie_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (MAX_SYMBOLS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (do_add),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata ({top, r_cum}),
        .i_re    (pop),
        .i_raddr (idx),
        .o_rdata (seg_data)
    );

    // Table update on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cum   <= '0;
        end else if (pop && (i_cmd.kind == OP_CLEAR)) begin
            r_count <= '0;
            r_cum   <= '0;
        end else if (do_add) begin
            r_count <= r_count + COUNT_W'(1);
            r_cum   <= top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_add) begin
            r_sym[r_count[ADDR_W-1:0]] <= i_cmd.symbol;
        end
    end

    // Lookup-to-execute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s2_kind  <= i_cmd.kind;
            r_s2_found <= found;
            r_s2_full  <= full;
            r_s2_last  <= i_cmd.last;
        end
    end

    // Narrowing: two truncated products against the current span
    always_comb begin
        seg_lo  = seg_data[VAL_W-1:0];
        seg_hi  = seg_data[2*VAL_W-1:VAL_W];
        span    = r_upper - r_lower;
        prod_lo = PROD_W'(span) * PROD_W'(seg_lo);
        prod_hi = PROD_W'(span) * PROD_W'(seg_hi);
        nlo     = r_lower + prod_lo[FRAC_BITS +: VAL_W];
        nhi     = r_lower + prod_hi[FRAC_BITS +: VAL_W];
        mid_sum = {1'b0, nlo} + {1'b0, nhi};
    end

    // Result and next interval per command kind
    always_comb begin
        n_lower                   = r_lower;
        n_upper                   = r_upper;
        n_out_item.interval_lower = r_lower;
        n_out_item.interval_upper = r_upper;
        n_out_item.code_value     = '0;
        n_out_item.code_valid     = 1'b0;
        n_out_item.status         = ST_OK;
        case (r_s2_kind)
            OP_CLEAR: begin
                n_lower                   = '0;
                n_upper                   = FX_ONE;
                n_out_item.interval_lower = '0;
                n_out_item.interval_upper = FX_ONE;
            end
            OP_ADD: begin
                if (r_s2_full) begin
                    n_out_item.status = ST_FULL;
                end
            end
            OP_ENCODE: begin
                if (!r_s2_found) begin
                    n_out_item.status = ST_UNKNOWN;
                end else begin
                    n_out_item.interval_lower = nlo;
                    n_out_item.interval_upper = nhi;
                    if (r_s2_last) begin
                        n_out_item.code_value = mid_sum[VAL_W:1];
                        n_out_item.code_valid = 1'b1;
                        n_lower               = '0;
                        n_upper               = FX_ONE;
                    end else begin
                        n_lower = nlo;
                        n_upper = nhi;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Interval state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower     <= '0;
            r_upper     <= FX_ONE;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid;
            if (r_s2_valid) begin
                r_lower <= n_lower;
                r_upper <= n_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_SYMBOLS))
        else $error("symbol table count past capacity");

    a_interval_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lower <= r_upper) && (r_upper <= FX_ONE))
        else $error("interval bounds out of order");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s2_valid && (r_s2_kind == OP_ENCODE) && r_s2_found && r_s2_last)
        |=> (r_lower == '0) && (r_upper == FX_ONE))
        else $error("interval not reset after last symbol");

    a_code_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.code_valid) |-> (r_out_item.status == ST_OK))
        else $error("code flagged valid with error status");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (i_cmd.kind == OP_ADD) && full) |=> $stable(r_count) && $stable(r_cum))
        else $error("table changed on add while full");

endmodule

[sv/arithmetic_interval_encoder_core.sv]
// Top level of the arithmetic interval encoder: front, queue and back end.
//
//  Channel  Valid        Ready        Payload      Dir
//  input    i_in_valid   o_in_ready   i_in_item    in
//  result   o_out_valid  i_out_ready  o_out_item   out
//
// One item per cycle sustained while i_out_ready holds; an accepted item is
// registered in the queue slot, the lookup stage with the segment RAM read, and the execute stage.
// The clock bound is the interval loop: subtract, 33x33 multiply, add.
// Synchronous active-low reset clears the count, running sum and interval;
// table entries are only read below the count, so no clearing pass is run.
// A stalled result holds the back end; the two-slot queue then fills and
// drops o_in_ready.
`timescale 1ns / 1ps

module arithmetic_interval_encoder_core import aie_pkg::*; #(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_q_wr q_wr;
    t_cmd  front_cmd;
    t_cmd  head_cmd;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    // Classify incoming items
    aie_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr),
        .o_cmd      (front_cmd)
    );

    // Decoupling queue
    aie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd)
    );

    // Table and interval execution
    aie_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[test/tb.sv]
// Self-checking testbench for the arithmetic interval encoder core.
`timescale 1ns / 1ps

module tb;
    import aie_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_SYMBOLS;
    localparam int RANDOM_ITEMS = 750;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam logic [VAL_W-1:0] HALF = FX_ONE >> 1;
    localparam logic [VAL_W-1:0] QUARTER = FX_ONE >> 2;
    localparam logic [VAL_W-1:0] SIXTEENTH = FX_ONE >> 4;
    localparam logic [VAL_W-1:0] PROB_MAX = '1;

    // One planned input item; result is used only when typed is set
    typedef struct {
        t_in_item  item;
        int        reps;
        bit        typed;
        t_out_item result;
    } t_stim_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Typed expectation riding along with the payload
    logic      in_typed = 1'b0;
    t_out_item in_typed_out = '0;

    t_stim_row dir_rows[$];
    t_stim_row item_plan[$];
    t_out_item expected_results[$];

    int cyc = 0;
    int quiet_cycles = 0;
    int fails = 0;
    int mismatches = 0;

    // Encoder model state
    logic [SYM_W-1:0] tab_sym[TABLE_DEPTH];
    logic [VAL_W-1:0] tab_lo[TABLE_DEPTH];
    logic [VAL_W-1:0] tab_hi[TABLE_DEPTH];
    int               tab_count = 0;
    logic [VAL_W-1:0] cum_val = '0;
    logic [VAL_W-1:0] cur_lo = '0;
    logic [VAL_W-1:0] cur_hi = FX_ONE;

    arithmetic_interval_encoder_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_in_item mk_in(input t_op op, input logic [SYM_W-1:0] sym,
                                       input logic [VAL_W-1:0] prob, input logic last);
        t_in_item it;
        it.operation = op;
        it.symbol = sym;
        it.probability = prob;
        it.last = last;
        return it;
    endfunction

    function automatic t_out_item mk_out(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
                                         input logic [VAL_W-1:0] code, input logic code_ok,
                                         input t_status st);
        t_out_item r;
        r.interval_lower = lo;
        r.interval_upper = hi;
        r.code_value = code;
        r.code_valid = code_ok;
        r.status = st;
        return r;
    endfunction

    // Append one row to the directed table
    task automatic add_dir(input t_in_item it, input int reps, input bit typed,
                           input t_out_item res);
        t_stim_row row;
        row.item = it;
        row.reps = reps;
        row.typed = typed;
        row.result = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Random 33-bit probability, top bit included
    function automatic logic [VAL_W-1:0] rand_prob();
        return {1'($urandom), 32'($urandom)};
    endfunction

    // Idle roll, disabled over a fixed window of the run
    function automatic bit take_break();
        if (cyc >= 300 && cyc < 700)
            return 1'b0;
        return $urandom_range(99) < 16;
    endfunction

    // Truncated Q1.32 product
    function automatic logic [VAL_W-1:0] scale_q(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [2*VAL_W-1:0] prod;
        prod = a * b;
        return prod[FRAC_BITS +: VAL_W];
    endfunction

    // Next result of the encoder for one item, updating the model state
    function automatic t_out_item predict_interval(input t_in_item it);
        t_out_item r;
        logic [VAL_W:0] top;
        logic [VAL_W-1:0] p;
        logic [VAL_W-1:0] span;
        logic [VAL_W-1:0] nlo;
        logic [VAL_W-1:0] nhi;
        int hit;
        r = mk_out(cur_lo, cur_hi, '0, 1'b0, ST_OK);
        case (t_op'(it.operation))
            OP_CLEAR: begin
                tab_count = 0;
                cum_val = '0;
                cur_lo = '0;
                cur_hi = FX_ONE;
                r.interval_lower = '0;
                r.interval_upper = FX_ONE;
            end
            OP_ADD: begin
                if (tab_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    p = (it.probability > FX_ONE) ? FX_ONE : it.probability;
                    top = {1'b0, cum_val} + p;
                    if (top > FX_ONE)
                        top = FX_ONE;
                    tab_sym[tab_count] = it.symbol;
                    tab_lo[tab_count] = cum_val;
                    tab_hi[tab_count] = top[VAL_W-1:0];
                    cum_val = top[VAL_W-1:0];
                    tab_count++;
                end
            end
            OP_ENCODE: begin
                // first matching entry wins
                hit = -1;
                for (int i = tab_count - 1; i >= 0; i--)
                    if (tab_sym[i] == it.symbol)
                        hit = i;
                if (hit < 0) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    span = cur_hi - cur_lo;
                    nlo = cur_lo + scale_q(span, tab_lo[hit]);
                    nhi = cur_lo + scale_q(span, tab_hi[hit]);
                    r.interval_lower = nlo;
                    r.interval_upper = nhi;
                    if (it.last) begin
                        r.code_value = VAL_W'(({1'b0, nlo} + nhi) >> 1);
                        r.code_valid = 1'b1;
                        cur_lo = '0;
                        cur_hi = FX_ONE;
                    end else begin
                        cur_lo = nlo;
                        cur_hi = nhi;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Directed table: rows with a typed result are read straight off the spec
    task automatic plan_directed();
        t_out_item reset_ok;
        t_out_item none;
        reset_ok = mk_out('0, FX_ONE, '0, 1'b0, ST_OK);
        none = '0;
        // empty table, unknown symbol even with last
        add_dir(mk_in(OP_ENCODE, 8'h00, '0, 1'b1), 1, 1'b1,
                mk_out('0, FX_ONE, '0, 1'b0, ST_UNKNOWN));
        add_dir(mk_in(OP_ADD, 8'h00, '0, 1'b0), 1, 1'b1, reset_ok);
        add_dir(mk_in(OP_NONE, 8'hFF, PROB_MAX, 1'b1), 1, 1'b1, reset_ok);
        add_dir(mk_in(OP_CLEAR, 8'hFF, PROB_MAX, 1'b1), 1, 1'b1, reset_ok);
        // probability above one saturates
        add_dir(mk_in(OP_ADD, 8'h41, PROB_MAX, 1'b1), 1, 1'b1, reset_ok);
        add_dir(mk_in(OP_ENCODE, 8'h41, '0, 1'b1), 1, 1'b1,
                mk_out('0, FX_ONE, HALF, 1'b1, ST_OK));
        // cumulative already at one: empty segment at the top
        add_dir(mk_in(OP_ADD, 8'h42, VAL_W'(5), 1'b0), 1, 1'b1, reset_ok);
        add_dir(mk_in(OP_ENCODE, 8'h42, '0, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ENCODE, 8'h41, '0, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_NONE, 8'h00, '0, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_CLEAR, 8'h00, '0, 1'b0), 1, 1'b1, reset_ok);
        // mixed table with a duplicate and a zero-width entry
        add_dir(mk_in(OP_ADD, 8'h00, QUARTER, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ADD, 8'hFF, HALF, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ADD, 8'h00, QUARTER, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ADD, 8'h55, '0, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ADD, 8'h80, FX_ONE, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ENCODE, 8'hFF, PROB_MAX, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ENCODE, 8'h00, '0, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ENCODE, 8'h80, '0, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ENCODE, 8'h55, '0, 1'b1), 1, 1'b0, none);
        add_dir(mk_in(OP_ENCODE, 8'h77, '0, 1'b1), 1, 1'b1,
                mk_out('0, FX_ONE, '0, 1'b0, ST_UNKNOWN));
        // fill the table, then one more
        add_dir(mk_in(OP_CLEAR, 8'h00, '0, 1'b0), 1, 1'b1, reset_ok);
        add_dir(mk_in(OP_ADD, 8'hF0, SIXTEENTH, 1'b0), TABLE_DEPTH, 1'b0, none);
        add_dir(mk_in(OP_ADD, 8'h01, HALF, 1'b0), 1, 1'b1,
                mk_out('0, FX_ONE, '0, 1'b0, ST_FULL));
        add_dir(mk_in(OP_ENCODE, 8'hFF, '0, 1'b0), 1, 1'b0, none);
        add_dir(mk_in(OP_ENCODE, 8'hF0, '0, 1'b1), 1, 1'b0, none);

        // walk the table, stepping the symbol on repeated rows
        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                t_stim_row row;
                row = dir_rows[r];
                row.item.symbol = row.item.symbol + SYM_W'(k);
                row.reps = 1;
                item_plan.insert(item_plan.size(), row);
            end
        end
    endtask

    // Random part: mostly clear / build table / encode messages, some noise
    task automatic plan_random();
        logic [SYM_W-1:0] known[$];
        t_stim_row row;
        logic [VAL_W-1:0] p;
        int counted;
        int n_add;
        int n_msg;
        int len;
        row.reps = 1;
        row.typed = 1'b0;
        row.result = '0;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 85) begin
                // sometimes keep the old table so it runs full
                if ($urandom_range(9) != 0) begin
                    row.item = mk_in(OP_CLEAR, 8'($urandom), rand_prob(), 1'($urandom));
                    item_plan.insert(item_plan.size(), row);
                    known.delete();
                    counted++;
                end
                n_add = ($urandom_range(9) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 16);
                for (int a = 0; a < n_add; a++) begin
                    case ($urandom_range(9))
                        0: p = rand_prob();
                        1: p = '0;
                        2: p = FX_ONE;
                        default: p = VAL_W'($urandom / n_add);
                    endcase
                    row.item = mk_in(OP_ADD, 8'($urandom), p, 1'($urandom));
                    if (known.size() > 0 && $urandom_range(9) == 0)
                        row.item.symbol = known[$urandom_range(known.size() - 1)];
                    if (known.size() < TABLE_DEPTH)
                        known.insert(known.size(), row.item.symbol);
                    item_plan.insert(item_plan.size(), row);
                    counted++;
                end
                n_msg = $urandom_range(1, 3);
                for (int m = 0; m < n_msg; m++) begin
                    len = $urandom_range(1, 8);
                    for (int s = 0; s < len; s++) begin
                        row.item = mk_in(OP_ENCODE, 8'($urandom), rand_prob(), s == len - 1);
                        if (known.size() > 0 && $urandom_range(9) != 0)
                            row.item.symbol = known[$urandom_range(known.size() - 1)];
                        item_plan.insert(item_plan.size(), row);
                        counted++;
                    end
                end
            end else begin
                row.item = mk_in(t_op'($urandom_range(3)), 8'($urandom), rand_prob(),
                                 1'($urandom));
                item_plan.insert(item_plan.size(), row);
                if (t_op'(row.item.operation) != OP_NONE)
                    counted++;
            end
        end
    endtask

    // Result side stalls at random
    always @(posedge clk)
        out_ready <= !take_break();

    // Model update on each accepted item, check on each accepted result
    always @(posedge clk) begin
        t_out_item want;
        t_out_item got;
        bit bad;
        cyc <= cyc + 1;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                want = predict_interval(in_item);
                if (in_typed)
                    want = in_typed_out;
                expected_results.insert(expected_results.size(), want);
            end
            if (out_valid && out_ready) begin
                got = out_item;
                if (expected_results.size() == 0) begin
                    fails++;
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: lo=%h hi=%h code=%h cv=%b st=%0d",
                                 got.interval_lower, got.interval_upper, got.code_value,
                                 got.code_valid, got.status);
                end else begin
                    want = expected_results.pop_front();
                    bad = (got.interval_lower !== want.interval_lower) ||
                          (got.interval_upper !== want.interval_upper) ||
                          (got.code_value !== want.code_value) ||
                          (got.code_valid !== want.code_valid) ||
                          (got.status !== want.status);
                    if (bad) begin
                        fails++;
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch exp: lo=%h hi=%h code=%h cv=%b st=%0d",
                                     want.interval_lower, want.interval_upper,
                                     want.code_value, want.code_valid, want.status);
                            $display("         got: lo=%h hi=%h code=%h cv=%b st=%0d",
                                     got.interval_lower, got.interval_upper,
                                     got.code_value, got.code_valid, got.status);
                        end
                    end
                end
            end
            // watchdog on cycles without any handshake
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("** arithmetic_interval_encoder_core: FAILED **");
                $finish;
            end
        end
    end

    // Reset, drive the plan, drain, report
    initial begin
        plan_directed();
        plan_random();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // each pass starts at the edge where the previous item was taken
        foreach (item_plan[n]) begin
            while (take_break()) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_item <= item_plan[n].item;
            in_typed <= item_plan[n].typed;
            in_typed_out <= item_plan[n].result;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && expected_results.size() == 0) begin
            $display("** arithmetic_interval_encoder_core: PASSED **");
        end else begin
            $display("** arithmetic_interval_encoder_core: FAILED **");
        end
        $finish;
    end

endmodule
